[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the window counter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while the reset is active.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, masked while the reset is active.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// Next-cycle implication that stays armed through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[design/lmwc_pkg.sv]
// ----------------------------------------------------------------------------
// lmwc_pkg
// Constants, payload structs and control types of the window counter.
// ----------------------------------------------------------------------------
package lmwc_pkg;

    localparam int MAX_TEXT = 1024;
    localparam int ALPHABET = 26;

    localparam int CMD_W    = 2;
    localparam int LETTER_W = 5;
    localparam int TOTAL_W  = 20;
    localparam int NEED_W   = 12;

    localparam int POS_W  = $clog2(MAX_TEXT + 1);
    localparam int ADDR_W = $clog2(MAX_TEXT);
    localparam int IDX_W  = $clog2(ALPHABET);
    localparam int OUTS_W = $clog2(ALPHABET + 1);

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [LETTER_W-1:0] letter;
    } lmwc_in_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_count;
        logic               covered;
        logic               overflow;
    } lmwc_out_t;

    typedef enum logic [1:0] {
        NEED_HOLD,
        NEED_INC,
        NEED_DEC
    } need_op_t;

    typedef struct packed {
        logic             clear;
        need_op_t         op;
        logic [IDX_W-1:0] idx;
    } need_ctrl_t;

    typedef struct packed {
        logic nonneg;
        logic none_outstanding;
    } need_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_ADD,
        ST_RESP
    } lmwc_state_t;

endpackage

[design/letter_multiset_window_counter.sv]
// ----------------------------------------------------------------------------
// letter_multiset_window_counter
// Counts text substrings whose letters cover a pattern multiset.
// ----------------------------------------------------------------------------
// One transaction in gives exactly one transaction out. Send pattern letters
// (cmd 1) first, then text letters (cmd 2); a clear (cmd 0) wipes all state.
// Each result carries the running substring total, the cover flag and an
// overflow flag for a letter dropped because 1024 letters were already held.
// A clear, pattern, dropped or ignored transaction goes from the decode
// state to the response state, and the response state waits while the
// output register is full. A text letter goes on from decode to a scan-read
// state, and to the response while the window is not yet covered. Once
// covered, the left edge steps past surplus letters, each step a scan-read
// and a scan-check state, and an add state ends the scan when the left edge
// runs up to the newest letter or stops on a letter that is still needed.
// The scan is set by the single read port of the text buffer and the one
// shared need-count adder: each left-edge step is one buffer read and one
// need update. The left edge moves at most once per stored letter. The
// result is held in an output register, so the next transaction is accepted
// while a result still waits to be taken.
// ----------------------------------------------------------------------------
module letter_multiset_window_counter import lmwc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  lmwc_in_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output lmwc_out_t m_payload
);

    lmwc_state_t state_reg, state_next;

    // latched transaction
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [LETTER_W-1:0] ch_reg, ch_next;
    logic                over_reg, over_next;

    // window bookkeeping
    logic [POS_W-1:0]   left_pos_reg, left_pos_next;
    logic [POS_W-1:0]   right_pos_reg, right_pos_next;
    logic [POS_W-1:0]   pattern_len_reg, pattern_len_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    // output register
    logic      m_valid_reg, m_valid_next;
    lmwc_out_t m_payload_reg, m_payload_next;

    // text buffer port
    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [LETTER_W-1:0] ram_rd_data;

    need_ctrl_t need_ctrl;
    need_stat_t need_stat;

    logic ch_valid;

    lmwc_text_ram #(
        .DEPTH  (MAX_TEXT),
        .DATA_W (LETTER_W)
    ) u_text_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (right_pos_reg[ADDR_W-1:0]),
        .wr_data (ch_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (left_pos_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    lmwc_need_unit u_need (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (need_ctrl),
        .stat    (need_stat)
    );

    assign ch_valid = (ch_reg < LETTER_W'(ALPHABET));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            left_pos_reg    <= '0;
            right_pos_reg   <= '0;
            pattern_len_reg <= '0;
            total_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            left_pos_reg    <= left_pos_next;
            right_pos_reg   <= right_pos_next;
            pattern_len_reg <= pattern_len_next;
            total_reg       <= total_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        ch_reg        <= ch_next;
        over_reg      <= over_next;
        m_payload_reg <= m_payload_next;
    end

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        ch_next          = ch_reg;
        over_next        = over_reg;
        left_pos_next    = left_pos_reg;
        right_pos_next   = right_pos_reg;
        pattern_len_next = pattern_len_reg;
        total_next       = total_reg;
        m_payload_next   = m_payload_reg;
        m_valid_next     = m_valid_reg && !m_ready;

        s_ready   = 1'b0;
        ram_wr_en = 1'b0;
        ram_rd_en = 1'b0;

        need_ctrl.clear = 1'b0;
        need_ctrl.op    = NEED_HOLD;
        need_ctrl.idx   = ch_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next   = s_payload.cmd;
                    ch_next    = s_payload.letter;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE: begin
                over_next  = 1'b0;
                state_next = ST_RESP;
                if (cmd_reg == CMD_CLEAR) begin
                    // wipe the window; the buffer needs no clearing
                    need_ctrl.clear  = 1'b1;
                    left_pos_next    = '0;
                    right_pos_next   = '0;
                    pattern_len_next = '0;
                    total_next       = '0;
                end else if (ch_valid && cmd_reg == CMD_PATTERN) begin
                    // drop pattern letters once text has started
                    if (right_pos_reg == '0) begin
                        if (pattern_len_reg >= POS_W'(MAX_TEXT)) begin
                            over_next = 1'b1;
                        end else begin
                            need_ctrl.op     = NEED_INC;
                            pattern_len_next = pattern_len_reg + POS_W'(1);
                        end
                    end
                end else if (ch_valid && cmd_reg == CMD_TEXT) begin
                    if (right_pos_reg >= POS_W'(MAX_TEXT)) begin
                        over_next = 1'b1;
                    end else begin
                        ram_wr_en      = 1'b1;
                        need_ctrl.op   = NEED_DEC;
                        right_pos_next = right_pos_reg + POS_W'(1);
                        state_next     = ST_SCAN_RD;
                    end
                end
            end

            ST_SCAN_RD: begin
                // scan only while every needed letter is held
                if (!need_stat.none_outstanding) begin
                    state_next = ST_RESP;
                end else if (left_pos_reg + POS_W'(1) < right_pos_reg) begin
                    ram_rd_en  = 1'b1;
                    state_next = ST_SCAN_CHK;
                end else begin
                    state_next = ST_ADD;
                end
            end

            ST_SCAN_CHK: begin
                // advance past a surplus letter, else stop
                need_ctrl.idx = ram_rd_data[IDX_W-1:0];
                if (need_stat.nonneg) begin
                    state_next = ST_ADD;
                end else begin
                    need_ctrl.op  = NEED_INC;
                    left_pos_next = left_pos_reg + POS_W'(1);
                    state_next    = ST_SCAN_RD;
                end
            end

            ST_ADD: begin
                total_next = total_reg + TOTAL_W'(left_pos_reg) + TOTAL_W'(1);
                state_next = ST_RESP;
            end

            ST_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_payload_next.total_count = total_reg;
                    m_payload_next.covered     = need_stat.none_outstanding &&
                                                 (right_pos_reg != '0);
                    m_payload_next.overflow    = over_reg;
                    state_next                 = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

[design/lmwc_text_ram.sv]
// ----------------------------------------------------------------------------
// lmwc_text_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lmwc_text_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 5
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/lmwc_need_unit.sv]
// ----------------------------------------------------------------------------
// lmwc_need_unit
// Per-letter need counts with one shared +/-1 adder and the outstanding count.
// ----------------------------------------------------------------------------
module lmwc_need_unit import lmwc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  need_ctrl_t ctrl,
    output need_stat_t stat
);

    logic signed [NEED_W-1:0] need_count_reg [ALPHABET];
    logic [OUTS_W-1:0]        outstanding_reg;

    logic signed [NEED_W-1:0] cur;
    logic signed [NEED_W-1:0] step;
    logic signed [NEED_W-1:0] sum;

    assign cur  = need_count_reg[ctrl.idx];
    assign step = (ctrl.op == NEED_DEC) ? -NEED_W'(1) : NEED_W'(1);
    assign sum  = cur + step;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            for (int i = 0; i < ALPHABET; i++) begin
                need_count_reg[i] <= '0;
            end
            outstanding_reg <= '0;
        end else if (ctrl.op != NEED_HOLD) begin
            need_count_reg[ctrl.idx] <= sum;
            // count letters whose need turns positive, release on reaching zero
            if (ctrl.op == NEED_INC && sum == NEED_W'(1)) begin
                outstanding_reg <= outstanding_reg + OUTS_W'(1);
            end else if (ctrl.op == NEED_DEC && sum == '0 && outstanding_reg != '0) begin
                outstanding_reg <= outstanding_reg - OUTS_W'(1);
            end
        end
    end

    assign stat.nonneg           = ~cur[NEED_W-1];
    assign stat.none_outstanding = (outstanding_reg == '0);

endmodule

[design/lmwc_checker.sv]
// ----------------------------------------------------------------------------
// lmwc_checker
// Port-level checks of the window counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lmwc_checker import lmwc_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input lmwc_out_t m_payload
);

    // hold a stalled result
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))

    // drop any pending result on reset
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

    // one transaction at a time: busy right after acceptance
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a covered window has counted at least one substring
    `ASSERT_IMPLY(a_cover_counts, aclk, aresetn, m_valid && m_payload.covered,
        m_payload.total_count != '0)

endmodule

bind letter_multiset_window_counter lmwc_checker u_lmwc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for letter_multiset_window_counter.
// ----------------------------------------------------------------------------
// Walk a short table of directed transactions, fill the text store past
// capacity, take a longer pattern with some text, then run random
// pattern/text sequences with some noise mixed in. Every accepted transaction
// goes through a local window predictor, and each result transaction is
// compared with the oldest expectation. Both handshake sides idle at random;
// the receiver also holds off twice for a long stretch, and the sender drains
// the block once during the random sequences.
// ----------------------------------------------------------------------------
module tb;
    import lmwc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 480;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 60;
    localparam int MAX_REPORTS  = 10;

    // One row of the directed table. With known set, the typed result is the
    // expectation; otherwise the predictor supplies it.
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [LETTER_W-1:0] letter;
        logic                known;
        logic [TOTAL_W-1:0]  total;
        logic                covered;
        logic                overflow;
    } dir_row_t;

    localparam int DIR_ROWS = 24;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    lmwc_in_t  s_payload;
    logic      m_valid;
    logic      m_ready;
    lmwc_out_t m_payload;

    // Shared between the sender and the receiver processes.
    bit calm;
    bit hold_req;

    lmwc_out_t pending_results[$];
    int        fail_count;

    // Predictor state, at the block's widths.
    logic [LETTER_W-1:0]      win_text [MAX_TEXT];
    logic signed [NEED_W-1:0] win_need [ALPHABET];
    logic [OUTS_W-1:0]        win_missing;
    logic [POS_W-1:0]         win_left;
    logic [POS_W-1:0]         win_right;
    logic [TOTAL_W-1:0]       win_total;
    logic [POS_W-1:0]         win_pat_len;

    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        // after reset: clear, then an empty pattern makes every substring count
        '{CMD_CLEAR,   5'd7,  1'b1, 20'd0, 1'b0, 1'b0},
        '{CMD_TEXT,    5'd0,  1'b1, 20'd1, 1'b1, 1'b0},
        '{CMD_TEXT,    5'd25, 1'b1, 20'd3, 1'b1, 1'b0},
        // ignored: unused command, letter outside alphabet, pattern after text
        '{CMD_UNUSED,  5'd31, 1'b1, 20'd3, 1'b1, 1'b0},
        '{CMD_TEXT,    5'd31, 1'b1, 20'd3, 1'b1, 1'b0},
        '{CMD_PATTERN, 5'd3,  1'b1, 20'd3, 1'b1, 1'b0},
        '{CMD_CLEAR,   5'd31, 1'b1, 20'd0, 1'b0, 1'b0},
        '{CMD_PATTERN, 5'd26, 1'b1, 20'd0, 1'b0, 1'b0},
        // pattern a b a, then a text that covers it and slides
        '{CMD_PATTERN, 5'd0,  1'b1, 20'd0, 1'b0, 1'b0},
        '{CMD_PATTERN, 5'd1,  1'b1, 20'd0, 1'b0, 1'b0},
        '{CMD_PATTERN, 5'd0,  1'b1, 20'd0, 1'b0, 1'b0},
        '{CMD_TEXT,    5'd1,  1'b1, 20'd0, 1'b0, 1'b0},
        '{CMD_TEXT,    5'd0,  1'b0, 20'd0, 1'b0, 1'b0},
        '{CMD_TEXT,    5'd2,  1'b0, 20'd0, 1'b0, 1'b0},
        '{CMD_TEXT,    5'd0,  1'b0, 20'd0, 1'b0, 1'b0},
        '{CMD_TEXT,    5'd1,  1'b0, 20'd0, 1'b0, 1'b0},
        '{CMD_TEXT,    5'd0,  1'b0, 20'd0, 1'b0, 1'b0},
        '{CMD_PATTERN, 5'd25, 1'b0, 20'd0, 1'b0, 1'b0},
        '{CMD_UNUSED,  5'd16, 1'b0, 20'd0, 1'b0, 1'b0},
        '{CMD_TEXT,    5'd16, 1'b0, 20'd0, 1'b0, 1'b0},
        // single-letter pattern covered at once
        '{CMD_CLEAR,   5'd16, 1'b1, 20'd0, 1'b0, 1'b0},
        '{CMD_PATTERN, 5'd25, 1'b1, 20'd0, 1'b0, 1'b0},
        '{CMD_TEXT,    5'd25, 1'b1, 20'd1, 1'b1, 1'b0},
        '{CMD_TEXT,    5'd25, 1'b0, 20'd0, 1'b0, 1'b0}
    };

    letter_multiset_window_counter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Wipe the predicted window, as a clear transaction does.
    function automatic void window_clear();
        for (int i = 0; i < ALPHABET; i++) begin
            win_need[i] = '0;
        end
        win_missing = '0;
        win_left    = '0;
        win_right   = '0;
        win_total   = '0;
        win_pat_len = '0;
    endfunction

    // Advance the predicted window by one transaction and return its result.
    function automatic lmwc_out_t window_step(input lmwc_in_t item);
        lmwc_out_t res;
        logic      dropped;
        dropped = 1'b0;
        if (item.cmd == CMD_CLEAR) begin
            window_clear();
        end else if (item.letter < ALPHABET) begin
            if (item.cmd == CMD_PATTERN) begin
                // pattern letters only count before the first text letter
                if (win_right == 0) begin
                    if (win_pat_len >= MAX_TEXT) begin
                        dropped = 1'b1;
                    end else begin
                        win_need[item.letter] += 1;
                        if (win_need[item.letter] == 1) begin
                            win_missing += 1;
                        end
                        win_pat_len += 1;
                    end
                end
            end else if (item.cmd == CMD_TEXT) begin
                if (win_right >= MAX_TEXT) begin
                    dropped = 1'b1;
                end else begin
                    win_text[win_right] = item.letter;
                    win_need[item.letter] -= 1;
                    if (win_need[item.letter] == 0 && win_missing != 0) begin
                        win_missing -= 1;
                    end
                    win_right += 1;
                    if (win_missing == 0) begin
                        // step the left edge past surplus letters, never past the newest
                        while (win_left < win_right - 1 && win_need[win_text[win_left]] < 0) begin
                            win_need[win_text[win_left]] += 1;
                            win_left += 1;
                        end
                        win_total += TOTAL_W'(win_left) + 1'b1;
                    end
                end
            end
        end
        res.total_count = win_total;
        res.covered     = (win_missing == 0) && (win_right != 0);
        res.overflow    = dropped;
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len(input int short_max);
        if ($urandom_range(0, 11) == 0) begin
            return $urandom_range(15, 50);
        end
        return $urandom_range(0, short_max);
    endfunction

    // Offer one transaction, hold it until accepted, then log its expectation.
    task automatic offer(input lmwc_in_t item, input logic known, input lmwc_out_t typed);
        lmwc_out_t predicted;
        int        gap;
        gap = calm ? 0 : idle_len(2);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
        predicted = window_step(item);
        pending_results.insert(pending_results.size(), known ? typed : predicted);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random stalls, calm stretches, and a long hold-off on each request.
    initial begin
        m_ready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_ready <= 1'b0;
                repeat (idle_len(3) + 1) @(posedge aclk);
            end
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge aclk) begin : result_check
        lmwc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected result: total %0d covered %0b overflow %0b",
                             $realtime, m_payload.total_count, m_payload.covered,
                             m_payload.overflow);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_payload.total_count !== want.total_count ||
                    m_payload.covered !== want.covered ||
                    m_payload.overflow !== want.overflow) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch (exp/got): total %0d/%0d",
                                 $realtime, want.total_count, m_payload.total_count);
                        $display("    covered %0b/%0b overflow %0b/%0b",
                                 want.covered, m_payload.covered,
                                 want.overflow, m_payload.overflow);
                    end
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        lmwc_in_t item;
        int       counted;
        int       seq;
        int       base;
        int       span;
        int       pat_n;
        int       text_n;

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_payload  = '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        fail_count = 0;
        window_clear();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: extremes, every command and the ignored cases.
        for (int r = 0; r < DIR_ROWS; r++) begin
            item.cmd    = dir_rows[r].cmd;
            item.letter = dir_rows[r].letter;
            offer(item, dir_rows[r].known,
                  '{dir_rows[r].total, dir_rows[r].covered, dir_rows[r].overflow});
        end

        // Fill the text store with an empty pattern: the total peaks at its
        // maximum and the letters past capacity are dropped with overflow.
        calm = 1'b1;
        offer('{CMD_CLEAR, LETTER_W'(0)}, 1'b0, '0);
        calm = 1'b0;
        for (int i = 0; i < MAX_TEXT + 2; i++) begin
            if (i == 500) begin
                hold_req = 1'b1;
            end
            offer('{CMD_TEXT, LETTER_W'($urandom_range(0, ALPHABET - 1))}, 1'b0, '0);
        end

        // A longer pattern over a few letters, then some text to cover it.
        offer('{CMD_CLEAR, LETTER_W'($urandom_range(0, 31))}, 1'b0, '0);
        for (int i = 0; i < 30; i++) begin
            offer('{CMD_PATTERN, LETTER_W'($urandom_range(0, 3))}, 1'b0, '0);
        end
        for (int i = 0; i < 40; i++) begin
            offer('{CMD_TEXT, LETTER_W'($urandom_range(0, 3))}, 1'b0, '0);
        end

        // Random sequences: clear, a short pattern, then text drawn from a
        // narrow letter range so that covers and left-edge moves are common.
        counted = 0;
        seq     = 0;
        while (counted < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 5) == 0);
            span = $urandom_range(2, 4);
            base = $urandom_range(0, ALPHABET - span);
            if (seq == 4) begin
                hold_req = 1'b1;
            end
            if (seq == 10) begin
                // pause the sender until the block has answered everything
                s_valid <= 1'b0;
                drain_results();
            end
            if ($urandom_range(0, 7) != 0) begin
                offer('{CMD_CLEAR, LETTER_W'($urandom_range(0, 31))}, 1'b0, '0);
            end
            pat_n  = $urandom_range(0, 5);
            text_n = $urandom_range(1, 40);
            for (int i = 0; i < pat_n + text_n; i++) begin
                if ($urandom_range(0, 15) == 0) begin
                    case ($urandom_range(0, 3))
                        0: item = '{CMD_UNUSED, LETTER_W'($urandom_range(0, 31))};
                        1: item = '{CMD_TEXT, LETTER_W'($urandom_range(ALPHABET, 31))};
                        2: item = '{CMD_PATTERN, LETTER_W'($urandom_range(0, 31))};
                        default: item = '{CMD_CLEAR, LETTER_W'($urandom_range(0, 31))};
                    endcase
                end else begin
                    item.cmd    = (i < pat_n) ? CMD_PATTERN : CMD_TEXT;
                    item.letter = LETTER_W'(base + $urandom_range(0, span - 1));
                end
                offer(item, 1'b0, '0);
                if (item.cmd != CMD_UNUSED && item.letter < ALPHABET) begin
                    counted++;
                end
            end
            seq++;
        end

        s_valid <= 1'b0;
        calm = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("** letter_multiset_window_counter: PASSED **");
        end else begin
            $display("** letter_multiset_window_counter: FAILED **");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #20000000;
        $display("** letter_multiset_window_counter: FAILED **");
        $finish;
    end

endmodule
